@@ hdl/assert_macros.svh @@
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, off during reset
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in same cycle");

// implication checked in the next cycle, off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed one cycle later");

// implication checked in the next cycle, also across reset
`define ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed after reset");

`endif

@@ hdl/giq_pkg.sv @@
// package: constants and types of the gaussian quadrature block
package giq_pkg;

  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [63:0] Q30_HALF     = 64'h0000_0000_2000_0000;
  localparam logic [31:0] GAUSS_C0_Q24 = 32'd6693133;
  localparam logic [3:0]  HORNER_ORDER = 4'd8;
  localparam logic [2:0]  NUM_SQUARES  = 3'd5;

  // reciprocals for exact division of operands below 2^30, product shifted by RECIP_SHIFT
  localparam int          RECIP_SHIFT  = 33;
  localparam logic [31:0] RECIP_3      = 32'd2863311531;
  localparam logic [31:0] RECIP_5      = 32'd1717986919;
  localparam logic [31:0] RECIP_6      = 32'd1431655766;
  localparam logic [31:0] RECIP_7      = 32'd1227133514;

  localparam logic [1:0] RULE_S38  = 2'd0;
  localparam logic [1:0] RULE_S13  = 2'd1;
  localparam logic [1:0] RULE_TRAP = 2'd2;

  typedef enum logic [23:0] {
    ST_IDLE = 24'h000001,
    ST_NDIV = 24'h000002,
    ST_NDW  = 24'h000004,
    ST_XMUL = 24'h000008,
    ST_XDIV = 24'h000010,
    ST_XDW  = 24'h000020,
    ST_SQ   = 24'h000040,
    ST_SQW  = 24'h000080,
    ST_HMUL = 24'h000100,
    ST_HDIV = 24'h000200,
    ST_HDW  = 24'h000400,
    ST_PSQ  = 24'h000800,
    ST_PSQW = 24'h001000,
    ST_GMUL = 24'h002000,
    ST_GW   = 24'h004000,
    ST_ACC  = 24'h008000,
    ST_QDIV = 24'h010000,
    ST_QDW  = 24'h020000,
    ST_M1   = 24'h040000,
    ST_M2   = 24'h080000,
    ST_M3   = 24'h100000,
    ST_RDIV = 24'h200000,
    ST_RDW  = 24'h400000,
    ST_FIN  = 24'h800000
  } state_t;

endpackage

@@ hdl/giq_mul.sv @@
// shared 32 x 32 unsigned multiplier with registered product
module giq_mul (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(op_a) * 64'(op_b);
  end

endmodule

@@ hdl/giq_div.sv @@
// shared restoring divider, one quotient bit per cycle
module giq_div #(
  parameter int DW = 40,
  parameter int VW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quo,
  output logic [VW-1:0] rem,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [VW-1:0] dv;
  logic [VW:0]   shifted;
  logic          ge;

  always_comb begin
    shifted = {rem, quo[DW-1]};
    ge      = shifted >= {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= dividend;
        rem <= '0;
        dv  <= divisor;
        cnt <= CW'(DW);
      end else if (cnt != '0) begin
        quo <= {quo[DW-2:0], ge};
        rem <= ge ? VW'(shifted - {1'b0, dv}) : VW'(shifted);
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/gaussian_integral_quadrature.sv @@
// gaussian integral quadrature: top level with sequencer
//
// Integrates the normal density from lower_limit to upper_limit over
// partitions equal subintervals (Simpson 3/8, Simpson 1/3 or trapezoid).
// Input channel s_*: one transfer carries limits and count; s_tready is
// high only while the block is idle. Output channel m_*: one transfer per
// input with the saturated integral and the rule used.
// Each sample point costs one division for its abscissa on the shared
// divider and the exp series on the shared multiplier: eight Horner steps
// (a divide by 3, 5, 6 or 7 goes through a reciprocal product) and five
// squarings. Samples far out in the tail skip the series.
// A finished result sits in the output register; the next input is taken
// while it waits. If the receiver stalls, the sequencer holds in its last
// step until the output register frees up.
// Reset is synchronous: the sequencer returns to idle and m_tvalid drops.
module gaussian_integral_quadrature
  import giq_pkg::*;
#(
  parameter int MAX_PARTITIONS  = 1024,
  parameter int INPUT_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // lower_limit[23:0], upper_limit[47:24], partitions[58:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // integral[25:0], rule_used[27:26]
);

  localparam int F     = INPUT_FRAC_BITS;
  localparam int NW    = $clog2(MAX_PARTITIONS + 1);
  localparam int DVW   = NW + 3;
  localparam int SUM_W = 25 + NW;
  localparam int DIV_W = 29 + NW;
  localparam int ACC_W = 26 + SUM_W;
  localparam int TW    = ACC_W + 2;
  localparam int SH    = 2 * F + 6;
  localparam int SH_R  = (SH >= 30) ? SH - 30 : 0;
  localparam int SH_L  = (SH >= 30) ? 0 : 30 - SH;
  localparam logic [63:0] X2_LIMIT = 64'd32 << (2 * F);
  localparam logic signed [TW-1:0] HALF    = TW'(1) <<< (F - 1);
  localparam logic signed [TW-1:0] OUT_MAX = TW'(33554431);
  localparam logic signed [TW-1:0] OUT_MIN = -(TW'(33554432));

  state_t state;

  logic signed [23:0] a_r;
  logic        [24:0] absd;
  logic               d_neg;
  logic        [25:0] dm;
  logic      [NW-1:0] n_r;
  logic      [NW-1:0] i_r;
  logic         [1:0] i3;
  logic         [1:0] rule;
  logic     [DVW-1:0] dd;
  logic        [23:0] ax;
  logic        [29:0] s_r;
  logic        [30:0] p_r;
  logic         [3:0] k_r;
  logic         [2:0] sq_cnt;
  logic        [22:0] g_r;
  logic   [SUM_W-1:0] sum_r;
  logic   [SUM_W-1:0] q_r;
  logic     [DVW-1:0] r_r;
  logic   [ACC_W-1:0] acc;

  logic signed [23:0] lo_in;
  logic signed [23:0] up_in;
  logic signed [24:0] d_in;
  logic        [24:0] absd_in;
  logic        [31:0] n_ext;
  logic      [NW-1:0] n_in;

  logic        [31:0] mul_a;
  logic        [31:0] mul_b;
  logic        [63:0] mul_p;

  logic               div_start;
  logic   [DIV_W-1:0] div_dividend;
  logic     [DVW-1:0] div_divisor;
  logic   [DIV_W-1:0] div_q;
  logic     [DVW-1:0] div_r;
  logic               div_done;

  logic signed [25:0] xs;
  logic        [47:0] x2;
  logic        [63:0] s_wide;
  logic        [24:0] wg;
  logic         [2:0] w;
  logic signed [TW-1:0] t_sgn;
  logic signed [TW-1:0] t_rnd;
  logic signed [TW-1:0] t_sh;
  logic        [25:0] res;
  logic      [NW-1:0] n_q3;
  logic      [NW+1:0] n_q3x3;
  logic        [29:0] hy;
  logic        [29:0] hq_shift;
  logic        [31:0] k_recip;
  logic               k_pow2;
  logic               out_load;

  giq_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  giq_div #(
    .DW (DIV_W),
    .VW (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quo      (div_q),
    .rem      (div_r),
    .done     (div_done)
  );

  assign s_tready = (state == ST_IDLE);

  // input unpacking and count clamp
  always_comb begin
    lo_in   = s_tdata[23:0];
    up_in   = s_tdata[47:24];
    d_in    = 25'(up_in) - 25'(lo_in);
    absd_in = d_in[24] ? 25'(-d_in) : 25'(d_in);
    n_ext   = 32'(s_tdata[58:48]);
    if (n_ext == 32'd0) begin
      n_in = NW'(1);
    end else if (n_ext > 32'(MAX_PARTITIONS)) begin
      n_in = NW'(MAX_PARTITIONS);
    end else begin
      n_in = NW'(n_ext);
    end
  end

  // horner divide by k: shift for powers of two, reciprocal product otherwise
  always_comb begin
    hy       = mul_p[59:30];
    hq_shift = hy;
    k_recip  = '0;
    k_pow2   = 1'b1;
    case (k_r)
      4'd2:    hq_shift = hy >> 1;
      4'd4:    hq_shift = hy >> 2;
      4'd8:    hq_shift = hy >> 3;
      4'd3:    begin k_pow2 = 1'b0; k_recip = RECIP_3; end
      4'd5:    begin k_pow2 = 1'b0; k_recip = RECIP_5; end
      4'd6:    begin k_pow2 = 1'b0; k_recip = RECIP_6; end
      4'd7:    begin k_pow2 = 1'b0; k_recip = RECIP_7; end
      default: hq_shift = hy;
    endcase
  end

  // shared unit operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_NDIV: begin mul_a = 32'(n_r);  mul_b = RECIP_3; end
      ST_XMUL: begin mul_a = 32'(absd); mul_b = 32'(i_r); end
      ST_SQ:   begin mul_a = 32'(ax);   mul_b = 32'(ax);  end
      ST_HMUL: begin mul_a = 32'(s_r);  mul_b = 32'(p_r); end
      ST_HDIV: begin mul_a = 32'(hy);   mul_b = k_recip;  end
      ST_PSQ:  begin mul_a = 32'(p_r);  mul_b = 32'(p_r); end
      ST_GMUL: begin mul_a = GAUSS_C0_Q24; mul_b = 32'(p_r); end
      ST_M1:   begin mul_a = 32'(dm);   mul_b = q_r[31:0]; end
      ST_M2:   begin mul_a = 32'(dm);   mul_b = 32'(q_r[SUM_W-1:32]); end
      ST_M3:   begin mul_a = 32'(dm);   mul_b = 32'(r_r); end
      default: begin mul_a = '0;        mul_b = '0;        end
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = DVW'(1);
    case (state)
      ST_XDIV: begin
        div_start = 1'b1; div_dividend = DIV_W'(mul_p); div_divisor = DVW'(n_r);
      end
      ST_QDIV: begin
        div_start = 1'b1; div_dividend = DIV_W'(sum_r); div_divisor = dd;
      end
      ST_RDIV: begin
        div_start = 1'b1; div_dividend = DIV_W'(mul_p); div_divisor = dd;
      end
      default: begin
        div_start = 1'b0; div_dividend = '0; div_divisor = DVW'(1);
      end
    endcase
  end

  // datapath helpers
  always_comb begin
    n_q3   = NW'(mul_p >> RECIP_SHIFT);
    n_q3x3 = (NW+2)'(n_q3) + ((NW+2)'(n_q3) << 1);
    xs = 26'(a_r) + (d_neg ? -26'(div_q[24:0]) : 26'(div_q[24:0]));
    x2 = mul_p[47:0];
    s_wide = (SH >= 30) ? (64'(x2) >> SH_R) : (64'(x2) << SH_L);
    if (i_r == '0 || i_r == n_r) begin
      w = 3'd1;
    end else if (rule == RULE_S38) begin
      w = (i3 == 2'd0) ? 3'd2 : 3'd3;
    end else if (rule == RULE_S13) begin
      w = i_r[0] ? 3'd4 : 3'd2;
    end else begin
      w = 3'd2;
    end
    case (w)
      3'd4:    wg = 25'(g_r) << 2;
      3'd3:    wg = 25'(g_r) + (25'(g_r) << 1);
      3'd2:    wg = 25'(g_r) << 1;
      default: wg = 25'(g_r);
    endcase
    t_sgn = d_neg ? -$signed(TW'(acc)) : $signed(TW'(acc));
    t_rnd = t_sgn + HALF;
    t_sh  = t_rnd >>> F;
    if (t_sh > OUT_MAX) begin
      res = OUT_MAX[25:0];
    end else if (t_sh < OUT_MIN) begin
      res = OUT_MIN[25:0];
    end else begin
      res = t_sh[25:0];
    end
    out_load = (state == ST_FIN) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            a_r   <= lo_in;
            absd  <= absd_in;
            d_neg <= d_in[24];
            n_r   <= n_in;
            i_r   <= '0;
            i3    <= 2'd0;
            sum_r <= '0;
            state <= ST_NDIV;
          end
        end
        ST_NDIV: state <= ST_NDW;
        ST_NDW: begin
          if (n_q3x3 == (NW+2)'(n_r)) begin
            rule <= RULE_S38;
            dm   <= 26'(absd) + (26'(absd) << 1);
            dd   <= DVW'(n_r) << 3;
          end else if (!n_r[0]) begin
            rule <= RULE_S13;
            dm   <= 26'(absd);
            dd   <= DVW'(n_r) + (DVW'(n_r) << 1);
          end else begin
            rule <= RULE_TRAP;
            dm   <= 26'(absd);
            dd   <= DVW'(n_r) << 1;
          end
          state <= ST_XMUL;
        end
        ST_XMUL: state <= ST_XDIV;
        ST_XDIV: state <= ST_XDW;
        ST_XDW: begin
          if (div_done) begin
            ax    <= xs[25] ? 24'(-xs) : 24'(xs);
            state <= ST_SQ;
          end
        end
        ST_SQ: state <= ST_SQW;
        ST_SQW: begin
          if (64'(x2) > X2_LIMIT) begin
            g_r   <= '0;
            state <= ST_ACC;
          end else begin
            s_r   <= s_wide[29:0];
            p_r   <= Q30_ONE;
            k_r   <= HORNER_ORDER;
            state <= ST_HMUL;
          end
        end
        ST_HMUL: state <= ST_HDIV;
        ST_HDIV: begin
          if (k_pow2) begin
            p_r <= Q30_ONE - 31'(hq_shift);
            if (k_r == 4'd1) begin
              sq_cnt <= NUM_SQUARES;
              state  <= ST_PSQ;
            end else begin
              k_r   <= k_r - 4'd1;
              state <= ST_HMUL;
            end
          end else begin
            state <= ST_HDW;
          end
        end
        ST_HDW: begin
          p_r <= Q30_ONE - 31'(mul_p >> RECIP_SHIFT);
          if (k_r == 4'd1) begin
            sq_cnt <= NUM_SQUARES;
            state  <= ST_PSQ;
          end else begin
            k_r   <= k_r - 4'd1;
            state <= ST_HMUL;
          end
        end
        ST_PSQ: state <= ST_PSQW;
        ST_PSQW: begin
          p_r    <= 31'((mul_p + Q30_HALF) >> 30);
          sq_cnt <= sq_cnt - 3'd1;
          state  <= (sq_cnt == 3'd1) ? ST_GMUL : ST_PSQ;
        end
        ST_GMUL: state <= ST_GW;
        ST_GW: begin
          g_r   <= 23'((mul_p + Q30_HALF) >> 30);
          state <= ST_ACC;
        end
        ST_ACC: begin
          sum_r <= sum_r + SUM_W'(wg);
          if (i_r == n_r) begin
            state <= ST_QDIV;
          end else begin
            i_r   <= i_r + 1'b1;
            i3    <= (i3 == 2'd2) ? 2'd0 : i3 + 2'd1;
            state <= ST_XMUL;
          end
        end
        ST_QDIV: state <= ST_QDW;
        ST_QDW: begin
          if (div_done) begin
            q_r   <= div_q[SUM_W-1:0];
            r_r   <= div_r;
            state <= ST_M1;
          end
        end
        ST_M1: state <= ST_M2;
        ST_M2: begin
          acc   <= ACC_W'(mul_p);
          state <= ST_M3;
        end
        ST_M3: begin
          acc   <= acc + (ACC_W'(mul_p) << 32);
          state <= ST_RDIV;
        end
        ST_RDIV: state <= ST_RDW;
        ST_RDW: begin
          if (div_done) begin
            acc   <= acc + ACC_W'(div_q);
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            m_tdata  <= {4'd0, rule, res};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/giq_checker.sv @@
// port checker for the gaussian quadrature block and its bind
`include "assert_macros.svh"

module giq_checker
  import giq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [63:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  logic [1:0] rule_f;
  assign rule_f = m_tdata[27:26];

  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ASSERT_SAME(a_rule_code, m_tvalid, rule_f == RULE_S38 || rule_f == RULE_S13 || rule_f == RULE_TRAP)
  `ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)
  `ASSERT_NEXT_ALWAYS(a_reset_out, rst, !m_tvalid && s_tready)
  `ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[31:28] == 4'd0 && s_tdata == s_tdata)

endmodule

bind gaussian_integral_quadrature giq_checker u_giq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/sv/gaussian_integral_quadrature_tb.sv @@
// testbench for the gaussian integral quadrature block: directed and random items vs a predictor
module gaussian_integral_quadrature_tb;
  import giq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [25:0] integral;
    logic [1:0]         rule_used;
  } quad_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;  // lower_limit[23:0], upper_limit[47:24], partitions[58:48]
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;  // integral[25:0], rule_used[27:26]

  quad_result_t pending_integrals[$];
  int           error_count;
  int           items_sent;
  int           results_seen;
  int           large_count;

  gaussian_integral_quadrature i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint unsigned density_q24(longint x);
    longint unsigned ax;
    longint unsigned x2;
    longint unsigned s;
    longint unsigned p;
    longint unsigned t;
    ax = (x < 0) ? longint'(-x) : longint'(x);
    x2 = ax * ax;
    if (x2 > (64'd32 << 32)) return 0;
    s = x2 >> 8;
    p = 64'd1 << 30;
    for (int k = 8; k >= 1; k--) begin
      t = ((s * p) >> 30) / longint'(k);
      p = (64'd1 << 30) - t;
    end
    for (int k = 0; k < 5; k++) p = (p * p + (64'd1 << 29)) >> 30;
    return (64'd6693133 * p + (64'd1 << 29)) >> 30;
  endfunction

  function automatic quad_result_t integrate(logic [23:0] lo, logic [23:0] hi,
                                             logic [10:0] cnt);
    quad_result_t r;
    longint a, b, d, n, m, den, dd, q, rem, tot, res, w, x, sum;
    a = longint'($signed(lo));
    b = longint'($signed(hi));
    d = b - a;
    n = longint'(cnt);
    sum = 0;
    if (n < 1) n = 1;
    if (n > 1024) n = 1024;
    if (n % 3 == 0) begin
      r.rule_used = RULE_S38; m = 3; den = 8;
    end else if (n % 2 == 0) begin
      r.rule_used = RULE_S13; m = 1; den = 3;
    end else begin
      r.rule_used = RULE_TRAP; m = 1; den = 2;
    end
    for (longint i = 0; i <= n; i++) begin
      x = a + (d * i) / n;
      if (i == 0 || i == n) w = 1;
      else if (r.rule_used == RULE_S38) w = (i % 3 == 0) ? 2 : 3;
      else if (r.rule_used == RULE_S13) w = (i % 2 == 1) ? 4 : 2;
      else w = 2;
      sum += w * longint'(density_q24(x));
    end
    dd = n * den;
    q = sum / dd;
    rem = sum % dd;
    tot = d * m * q + (d * m * rem) / dd;
    tot += 64'sd32768;
    if (tot >= 0) res = tot >>> 16;
    else res = -((-tot + 65535) >>> 16);
    if (res < -(64'sd1 << 25)) res = -(64'sd1 << 25);
    if (res > (64'sd1 << 25) - 1) res = (64'sd1 << 25) - 1;
    r.integral = res[25:0];
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 150);
    return $urandom_range(1, 4);
  endfunction

  task automatic send_item(logic [23:0] lo, logic [23:0] hi, logic [10:0] cnt);
    int gap;
    s_tdata  <= {5'd0, cnt, hi, lo};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_integrals.push_back(integrate(lo, hi, cnt));
    items_sent++;
    if (cnt == 0 || cnt > 1024) large_count++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) m_tready <= 1'b1;
    else if ($urandom_range(0, 29) == 0) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 4) != 0);
  end

  always @(posedge clk) begin
    quad_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_integrals.size() == 0) begin
        $display("%0t: unexpected transfer, actual integral %0d rule %0d", $realtime,
                 $signed(m_tdata[25:0]), m_tdata[27:26]);
        error_count++;
      end else begin
        want = pending_integrals.pop_front();
        if (m_tdata[25:0] !== want.integral) begin
          $display("%0t: integral expected %0d actual %0d", $realtime,
                   want.integral, $signed(m_tdata[25:0]));
          error_count++;
        end
        if (m_tdata[27:26] !== want.rule_used) begin
          $display("%0t: rule expected %0d actual %0d", $realtime,
                   want.rule_used, m_tdata[27:26]);
          error_count++;
        end
      end
    end
  end

  function automatic logic [23:0] tail_limit(bit neg);
    logic [23:0] v;
    v = 24'($urandom_range(400000, 8388607));
    return neg ? -v : v;
  endfunction

  task automatic test_directed();
    send_item(24'd0, 24'd65536, 11'd2);
    send_item(-24'd65536, 24'd65536, 11'd3);
    send_item(-24'd131072, 24'd131072, 11'd1);
    send_item(24'd0, 24'd0, 11'd4);
    send_item(24'd65536, -24'd65536, 11'd6);
    send_item(24'h800000, 24'h7fffff, 11'd2);
    send_item(24'h7fffff, 24'h800000, 11'd2);
    send_item(24'h800000, 24'h7fffff, 11'd1);
    send_item(-24'd196608, 24'd196608, 11'd0);
    send_item(-24'd262144, 24'd262144, 11'd1024);
    send_item(24'd500000, 24'd8388607, 11'd2047);
    send_item(24'h800000, -24'd400000, 11'd1025);
    send_item(-24'd65536, 24'd32768, 11'd5);
    send_item(24'd12345, 24'd98765, 11'd12);
    send_item(-24'd300000, 24'd370000, 11'd9);
    send_item(24'd1, 24'd2, 11'd8);
  endtask

  task automatic test_random();
    logic [23:0] lo, hi;
    logic [10:0] cnt;
    int sel;
    for (int k = 0; k < 100; k++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        cnt = 11'($urandom_range(1025, 2047));
        lo = tail_limit($urandom_range(0, 1));
        hi = tail_limit(lo[23]);
      end else if (sel < 4) begin
        cnt = 11'($urandom_range(1, 12));
        lo = 24'($urandom);
        hi = 24'($urandom);
      end else begin
        cnt = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(13, 64))
                                          : 11'($urandom_range(1, 12));
        lo = 24'($signed($urandom_range(0, 524288)) - 262144);
        hi = 24'($signed($urandom_range(0, 524288)) - 262144);
      end
      send_item(lo, hi, cnt);
    end
  endtask

  initial begin
    int waited;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    error_count = 0;
    items_sent  = 0;
    results_seen = 0;
    large_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    s_tvalid <= 1'b0;
    waited = 0;
    while (pending_integrals.size() != 0 && waited < 2000000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    $display("covered %0d items (%0d with zero or clamped counts), %0d results checked",
             items_sent, large_count, results_seen);
    $display("all three rules, saturation both ways, reversed and far-tail limits");
    if (error_count == 0 && pending_integrals.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

endmodule
